/* src/ffca_pkg.sv */
// Shared types, constants and helpers for the first-fit coalescing allocator.
package ffca_pkg;

	localparam int unsigned ALIGN_BYTES   = 8;
	localparam int unsigned HEADER_BYTES  = 16;
	localparam int unsigned MAX_EXTENTS   = 16;
	localparam int unsigned HEAP_GRANULES = 4096;

	localparam int unsigned AW = 34;
	localparam int unsigned IW = $clog2(MAX_EXTENTS);
	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned GW = $clog2(HEAP_GRANULES);

	localparam logic [AW-1:0] SPAN      = AW'(longint'(HEAP_GRANULES) * longint'(ALIGN_BYTES));
	localparam logic [AW-1:0] HDR       = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] HDR_ROUND = AW'(HEADER_BYTES + ALIGN_BYTES - 1);
	localparam logic [AW-1:0] GRANULES  = AW'(HEAP_GRANULES);

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NULL  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_BASE  = 1'b0,
		CFG_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t       op;
		logic [AW-1:0] a;
		logic [AW-1:0] b;
	} alu_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RB_LO, S_RB_DIFF, S_RB_CMP, S_RB_CLAMP,
		S_A_NEED, S_A_SCAN, S_A_REM, S_A_SPLIT, S_A_HDR, S_A_GRANT,
		S_F_BLK, S_F_OFF, S_F_HI, S_F_LIM, S_F_CLAMP, S_F_SCAN,
		S_F_PREV, S_F_NEXT, S_F_MERGE, S_F_SUM2,
		S_SH_DN, S_SH_UP, S_FIN
	} state_t;

	function automatic logic [AW-1:0] floor_align(logic [AW-1:0] x);
		return (x / AW'(ALIGN_BYTES)) * AW'(ALIGN_BYTES);
	endfunction

endpackage

/* src/first_fit_coalescing_allocator.sv */
// Top level: first-fit heap allocator with address-ordered coalescing free table.
//
// Request channel: an item (mode, request_size, block_address) is taken when
// start is high and busy is low. busy stays high while the sequencer works.
// Result channel: done pulses for one cycle with status and granted_address;
// the receiver cannot stall, busy is already low in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 base, 1 limit) and
// cfg_data. cfg_ready is high only when idle and start is low; each write
// rebuilds the free table through the RB_ states and gives no result.
// Timing: address and size sums run through one shared 34-bit add/subtract
// unit, one operation per cycle. Allocate: align the request plus header,
// compare extents in order to the first fit, then split it or use it whole
// and shift later entries down, write the header and form the grant; no fit
// gives status NOFIT. Free: check the block address, bounds and alignment,
// read the stored header, clamp the size, scan for the position and test
// both neighbours; merge, insert with entries shifted up (FULL if the table
// is full), or merge both and shift down; early rejects give status NULL.
// Reset: base and limit are zero, table empty; the header store is not
// cleared and needs no sweep.
module first_fit_coalescing_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] request_size,
	input  logic [31:0] block_address,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] granted_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned AW = ffca_pkg::AW;
	localparam int unsigned IW = ffca_pkg::IW;
	localparam int unsigned CW = ffca_pkg::CW;
	localparam int unsigned GW = ffca_pkg::GW;

	ffca_pkg::state_t   state_q, state_d;
	ffca_pkg::alu_req_t alu_req;
	logic [AW-1:0]      alu_res;
	logic               alu_borrow;

	logic [31:0]   base_q, limit_q;
	logic [AW-1:0] lo_q, rhi_q;
	logic [CW-1:0] cnt_q, idx_q, p_q, j_q;
	logic          pos_q, prev_adj_q, next_adj_q, mode_q, done_q;
	logic [31:0]   addr_q, size_q;

	logic [AW-1:0] need_q, blk_q, t_q, bsize_q, lim_q;
	logic [31:0]   st_q [ffca_pkg::MAX_EXTENTS];
	logic [31:0]   sz_q [ffca_pkg::MAX_EXTENTS];
	ffca_pkg::status_t status_q;
	logic [31:0]   grant_q;

	logic [IW-1:0] ix, px, pm1, jx, jp1, jm1;
	logic [AW-1:0] hi_al, gidx;
	logic          ram_we, ram_re;
	logic [31:0]   ram_rdata;
	logic          cfg_fire, start_fire;

	assign ix  = idx_q[IW-1:0];
	assign px  = p_q[IW-1:0];
	assign pm1 = IW'(p_q - CW'(1));
	assign jx  = j_q[IW-1:0];
	assign jp1 = IW'(j_q + CW'(1));
	assign jm1 = IW'(j_q - CW'(1));
	assign hi_al = ffca_pkg::floor_align({2'b00, limit_q});
	assign gidx  = alu_res / AW'(ffca_pkg::ALIGN_BYTES);

	assign busy      = (state_q != ffca_pkg::S_IDLE);
	assign cfg_ready = (state_q == ffca_pkg::S_IDLE) & ~start;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign start_fire = start & ~busy;
	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = grant_q;

	ffca_alu u_alu (
		.req    (alu_req),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	ffca_hdr_ram u_hdr (
		.clk   (clk),
		.we    (ram_we),
		.waddr (gidx[GW-1:0]),
		.wdata (bsize_q[31:0]),
		.re    (ram_re),
		.raddr (GW'(t_q / AW'(ffca_pkg::ALIGN_BYTES))),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ALU operands, header store strobes
	always_comb begin
		state_d = state_q;
		alu_req = '{op: ffca_pkg::ALU_ADD, a: '0, b: '0};
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		unique case (state_q)
			ffca_pkg::S_IDLE: begin
				if (start) begin
					state_d = mode ? ffca_pkg::S_F_BLK : ffca_pkg::S_A_NEED;
				end else if (cfg_fire) begin
					state_d = ffca_pkg::S_RB_LO;
				end
			end
			ffca_pkg::S_RB_LO: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: {2'b00, base_q}, b: ffca_pkg::HDR_ROUND};
				state_d = ffca_pkg::S_RB_DIFF;
			end
			ffca_pkg::S_RB_DIFF: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: hi_al, b: lo_q};
				state_d = ffca_pkg::S_RB_CMP;
			end
			ffca_pkg::S_RB_CMP: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: ffca_pkg::SPAN, b: t_q};
				state_d = (pos_q && alu_borrow) ? ffca_pkg::S_RB_CLAMP : ffca_pkg::S_IDLE;
			end
			ffca_pkg::S_RB_CLAMP: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: lo_q, b: ffca_pkg::SPAN};
				state_d = ffca_pkg::S_IDLE;
			end
			ffca_pkg::S_A_NEED: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: {2'b00, size_q}, b: ffca_pkg::HDR_ROUND};
				state_d = ffca_pkg::S_A_SCAN;
			end
			ffca_pkg::S_A_SCAN: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: {2'b00, sz_q[ix]}, b: need_q};
				if (idx_q == cnt_q) begin
					state_d = ffca_pkg::S_FIN;
				end else if (!alu_borrow) begin
					state_d = ffca_pkg::S_A_REM;
				end
			end
			ffca_pkg::S_A_REM: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: ffca_pkg::HDR, b: t_q};
				state_d = alu_borrow ? ffca_pkg::S_A_SPLIT : ffca_pkg::S_SH_DN;
			end
			ffca_pkg::S_A_SPLIT: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: blk_q, b: need_q};
				state_d = ffca_pkg::S_A_HDR;
			end
			ffca_pkg::S_A_HDR: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: blk_q, b: lo_q};
				ram_we  = (gidx < ffca_pkg::GRANULES);
				state_d = ffca_pkg::S_A_GRANT;
			end
			ffca_pkg::S_A_GRANT: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: blk_q, b: ffca_pkg::HDR};
				state_d = ffca_pkg::S_FIN;
			end
			ffca_pkg::S_F_BLK: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: {2'b00, addr_q}, b: ffca_pkg::HDR};
				state_d = (addr_q == '0 || alu_borrow) ? ffca_pkg::S_FIN : ffca_pkg::S_F_OFF;
			end
			ffca_pkg::S_F_OFF: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: blk_q, b: lo_q};
				state_d = alu_borrow ? ffca_pkg::S_FIN : ffca_pkg::S_F_HI;
			end
			ffca_pkg::S_F_HI: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: blk_q, b: rhi_q};
				if (!alu_borrow || (t_q % AW'(ffca_pkg::ALIGN_BYTES)) != '0 ||
				    (t_q / AW'(ffca_pkg::ALIGN_BYTES)) >= ffca_pkg::GRANULES) begin
					state_d = ffca_pkg::S_FIN;
				end else begin
					ram_re  = 1'b1;
					state_d = ffca_pkg::S_F_LIM;
				end
			end
			ffca_pkg::S_F_LIM: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: rhi_q, b: blk_q};
				state_d = ffca_pkg::S_F_CLAMP;
			end
			ffca_pkg::S_F_CLAMP: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: lim_q, b: {2'b00, ram_rdata}};
				state_d = ffca_pkg::S_F_SCAN;
			end
			ffca_pkg::S_F_SCAN: begin
				alu_req = '{op: ffca_pkg::ALU_SUB, a: blk_q, b: {2'b00, st_q[ix]}};
				if (idx_q == cnt_q || alu_borrow) begin
					state_d = ffca_pkg::S_F_PREV;
				end
			end
			ffca_pkg::S_F_PREV: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: {2'b00, st_q[pm1]}, b: {2'b00, sz_q[pm1]}};
				state_d = ffca_pkg::S_F_NEXT;
			end
			ffca_pkg::S_F_NEXT: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: blk_q, b: bsize_q};
				state_d = ffca_pkg::S_F_MERGE;
			end
			ffca_pkg::S_F_MERGE: begin
				if (prev_adj_q) begin
					alu_req = '{op: ffca_pkg::ALU_ADD, a: {2'b00, sz_q[pm1]}, b: bsize_q};
					state_d = next_adj_q ? ffca_pkg::S_F_SUM2 : ffca_pkg::S_FIN;
				end else if (next_adj_q) begin
					alu_req = '{op: ffca_pkg::ALU_ADD, a: {2'b00, sz_q[px]}, b: bsize_q};
					state_d = ffca_pkg::S_FIN;
				end else begin
					state_d = (cnt_q >= CW'(ffca_pkg::MAX_EXTENTS)) ? ffca_pkg::S_FIN
					                                                 : ffca_pkg::S_SH_UP;
				end
			end
			ffca_pkg::S_F_SUM2: begin
				alu_req = '{op: ffca_pkg::ALU_ADD, a: t_q, b: {2'b00, sz_q[px]}};
				state_d = ffca_pkg::S_SH_DN;
			end
			ffca_pkg::S_SH_DN: begin
				if (!(j_q + CW'(1) < cnt_q)) begin
					state_d = mode_q ? ffca_pkg::S_FIN : ffca_pkg::S_A_HDR;
				end
			end
			ffca_pkg::S_SH_UP: begin
				if (!(j_q > p_q)) begin
					state_d = ffca_pkg::S_FIN;
				end
			end
			ffca_pkg::S_FIN: begin
				state_d = ffca_pkg::S_IDLE;
			end
			default: state_d = ffca_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			limit_q    <= '0;
			lo_q       <= ffca_pkg::HDR;
			rhi_q      <= ffca_pkg::HDR;
			cnt_q      <= '0;
			idx_q      <= '0;
			p_q        <= '0;
			j_q        <= '0;
			pos_q      <= 1'b0;
			prev_adj_q <= 1'b0;
			next_adj_q <= 1'b0;
			mode_q     <= 1'b0;
			done_q     <= 1'b0;
			addr_q     <= '0;
			size_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ffca_pkg::S_IDLE: begin
					if (start_fire) begin
						mode_q <= mode;
						addr_q <= block_address;
						size_q <= request_size;
						idx_q  <= '0;
					end else if (cfg_fire) begin
						if (cfg_index == ffca_pkg::CFG_BASE) begin
							base_q <= cfg_data;
						end else begin
							limit_q <= cfg_data;
						end
					end
				end
				ffca_pkg::S_RB_LO:   lo_q <= ffca_pkg::floor_align(alu_res);
				ffca_pkg::S_RB_DIFF: pos_q <= ~alu_borrow && (alu_res != '0);
				ffca_pkg::S_RB_CMP: begin
					if (!pos_q) begin
						rhi_q <= lo_q;
						cnt_q <= '0;
					end else begin
						rhi_q <= hi_al;
						cnt_q <= CW'(1);
					end
				end
				ffca_pkg::S_RB_CLAMP: rhi_q <= alu_res;
				ffca_pkg::S_A_SCAN: begin
					if (idx_q != cnt_q) begin
						if (!alu_borrow) begin
							p_q <= idx_q;
							j_q <= idx_q;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ffca_pkg::S_F_SCAN: begin
					if (idx_q == cnt_q || alu_borrow) begin
						p_q <= idx_q;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ffca_pkg::S_F_CLAMP: idx_q <= '0;
				ffca_pkg::S_F_PREV:  prev_adj_q <= (p_q != '0) && (alu_res == blk_q);
				ffca_pkg::S_F_NEXT:  next_adj_q <= (p_q < cnt_q) && (alu_res == {2'b00, st_q[px]});
				ffca_pkg::S_F_MERGE: j_q <= cnt_q;
				ffca_pkg::S_F_SUM2:  j_q <= p_q;
				ffca_pkg::S_SH_DN: begin
					if (j_q + CW'(1) < cnt_q) begin
						j_q <= j_q + CW'(1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ffca_pkg::S_SH_UP: begin
					if (j_q > p_q) begin
						j_q <= j_q - CW'(1);
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ffca_pkg::S_FIN: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers and extent table
	always_ff @(posedge clk) begin
		case (state_q)
			ffca_pkg::S_IDLE: begin
				if (start_fire) begin
					status_q <= ffca_pkg::ST_DONE;
					grant_q  <= '0;
				end
			end
			ffca_pkg::S_RB_DIFF: t_q <= alu_res;
			ffca_pkg::S_RB_CMP: begin
				st_q[0] <= lo_q[31:0];
				sz_q[0] <= alu_borrow ? ffca_pkg::SPAN[31:0] : t_q[31:0];
			end
			ffca_pkg::S_A_NEED: need_q <= ffca_pkg::floor_align(alu_res);
			ffca_pkg::S_A_SCAN: begin
				if (idx_q == cnt_q) begin
					status_q <= ffca_pkg::ST_NOFIT;
				end else if (!alu_borrow) begin
					t_q     <= alu_res;
					blk_q   <= {2'b00, st_q[ix]};
					bsize_q <= {2'b00, sz_q[ix]};
				end
			end
			ffca_pkg::S_A_SPLIT: begin
				st_q[px] <= alu_res[31:0];
				sz_q[px] <= t_q[31:0];
				bsize_q  <= need_q;
			end
			ffca_pkg::S_A_GRANT: grant_q <= alu_res[31:0];
			ffca_pkg::S_F_BLK: begin
				blk_q <= alu_res;
				if (addr_q == '0 || alu_borrow) begin
					status_q <= ffca_pkg::ST_NULL;
				end
			end
			ffca_pkg::S_F_OFF: begin
				t_q <= alu_res;
				if (alu_borrow) begin
					status_q <= ffca_pkg::ST_NULL;
				end
			end
			ffca_pkg::S_F_HI: begin
				if (!alu_borrow || (t_q % AW'(ffca_pkg::ALIGN_BYTES)) != '0 ||
				    (t_q / AW'(ffca_pkg::ALIGN_BYTES)) >= ffca_pkg::GRANULES) begin
					status_q <= ffca_pkg::ST_NULL;
				end
			end
			ffca_pkg::S_F_LIM:   lim_q <= alu_res;
			ffca_pkg::S_F_CLAMP: bsize_q <= alu_borrow ? lim_q : {2'b00, ram_rdata};
			ffca_pkg::S_F_MERGE: begin
				if (prev_adj_q) begin
					t_q <= alu_res;
					if (!next_adj_q) begin
						sz_q[pm1] <= alu_res[31:0];
					end
				end else if (next_adj_q) begin
					st_q[px] <= blk_q[31:0];
					sz_q[px] <= alu_res[31:0];
				end else if (cnt_q >= CW'(ffca_pkg::MAX_EXTENTS)) begin
					status_q <= ffca_pkg::ST_FULL;
				end
			end
			ffca_pkg::S_F_SUM2: sz_q[pm1] <= alu_res[31:0];
			ffca_pkg::S_SH_DN: begin
				if (j_q + CW'(1) < cnt_q) begin
					st_q[jx] <= st_q[jp1];
					sz_q[jx] <= sz_q[jp1];
				end
			end
			ffca_pkg::S_SH_UP: begin
				if (j_q > p_q) begin
					st_q[jx] <= st_q[jm1];
					sz_q[jx] <= sz_q[jm1];
				end else begin
					st_q[px] <= blk_q[31:0];
					sz_q[px] <= bsize_q[31:0];
				end
			end
			default: ;
		endcase
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ffca_pkg::MAX_EXTENTS))
		else $error("extent count above table depth");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
endmodule

/* src/ffca_alu.sv */
// Shared add/subtract unit with borrow flag.
module ffca_alu (
	input  ffca_pkg::alu_req_t          req,
	output logic [ffca_pkg::AW-1:0]     res,
	output logic                        borrow
);
	logic [ffca_pkg::AW:0] full;
	logic                  sub;

	always_comb begin
		sub  = (req.op == ffca_pkg::ALU_SUB);
		full = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + (ffca_pkg::AW + 1)'(sub);
	end

	assign res    = full[ffca_pkg::AW-1:0];
	assign borrow = sub & ~full[ffca_pkg::AW];
endmodule

/* src/ffca_hdr_ram.sv */
// Block size header store, one write and one registered read port.
module ffca_hdr_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ffca_pkg::GW-1:0]  waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [ffca_pkg::GW-1:0]  raddr,
	output logic [31:0]              rdata
);
	logic [31:0] mem [ffca_pkg::HEAP_GRANULES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
